[design/pcsm_pkg.sv]
// Shared types, opcode codes and status codes of the p-code stack machine.
package pcsm_pkg;

   localparam int WORD_BITS = 32;
   localparam int STACK_DEPTH_DEF = 4096;
   localparam int MAX_LEVEL_DEF = 7;

   // instruction opcodes
   localparam logic [3:0] OP_LIT  = 4'd0;
   localparam logic [3:0] OP_LOD  = 4'd1;
   localparam logic [3:0] OP_STO  = 4'd2;
   localparam logic [3:0] OP_INT  = 4'd3;
   localparam logic [3:0] OP_JMP  = 4'd4;
   localparam logic [3:0] OP_JPC  = 4'd5;
   localparam logic [3:0] OP_OPR  = 4'd6;
   localparam logic [3:0] OP_RED  = 4'd7;
   localparam logic [3:0] OP_WRI  = 4'd8;
   localparam logic [3:0] OP_LOD1 = 4'd9;
   localparam logic [3:0] OP_GTA  = 4'd10;
   localparam logic [3:0] OP_CAL  = 4'd11;
   localparam logic [3:0] OP_STO1 = 4'd12;

   // OPR function codes
   localparam int OPR_RET  = 0;
   localparam int OPR_NOT  = 1;
   localparam int OPR_ADD  = 2;
   localparam int OPR_SUB  = 3;
   localparam int OPR_MUL  = 4;
   localparam int OPR_DIV  = 5;
   localparam int OPR_ODD  = 6;
   localparam int OPR_NONE = 7;
   localparam int OPR_EQ   = 8;
   localparam int OPR_NE   = 9;
   localparam int OPR_LT   = 10;
   localparam int OPR_GE   = 11;
   localparam int OPR_GT   = 12;
   localparam int OPR_LE   = 13;
   localparam int OPR_MOD  = 14;
   localparam int OPR_XOR  = 15;
   localparam int OPR_AND  = 16;
   localparam int OPR_OR   = 17;
   localparam int OPR_HALT = 18;

   // result status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_END   = 3'd1;
   localparam logic [2:0] ST_HALT  = 3'd2;
   localparam logic [2:0] ST_DIV0  = 3'd3;
   localparam logic [2:0] ST_MOD0  = 3'd4;
   localparam logic [2:0] ST_ILL   = 3'd5;
   localparam logic [2:0] ST_FAULT = 3'd6;

   typedef struct packed {
      logic [3:0]                  opcode;
      logic [2:0]                  level;
      logic signed [WORD_BITS-1:0] operand;
      logic signed [WORD_BITS-1:0] read_value;
   } req_item_type;

   typedef struct packed {
      logic [15:0]                 next_pc;
      logic [2:0]                  status;
      logic                        write_valid;
      logic signed [WORD_BITS-1:0] write_value;
   } rsp_item_type;

   typedef struct packed {
      logic start;
      logic want_rem;
   } div_req_type;

endpackage

[design/pcsm_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module pcsm_div import pcsm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  div_req_type                 req,
   input  logic signed [WORD_BITS-1:0] dividend,
   input  logic signed [WORD_BITS-1:0] divisor,
   output logic                        done,
   output logic signed [WORD_BITS-1:0] result
);

   localparam int CW = $clog2(WORD_BITS + 1);

   logic              run_ff, run_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] quo_ff, quo_in, rem_ff, rem_in, mb_ff, mb_in;
   logic              neg_q_ff, neg_q_in, neg_r_ff, neg_r_in, rem_sel_ff, rem_sel_in;
   logic              done_ff, done_in;
   logic [WORD_BITS:0]   rem_sh, trial;

   // one restoring step
   always_comb begin
      rem_sh = {rem_ff, quo_ff[WORD_BITS-1]};
      trial  = rem_sh - {1'b0, mb_ff};
   end

   always_comb begin
      run_in     = run_ff;
      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      mb_in      = mb_ff;
      neg_q_in   = neg_q_ff;
      neg_r_in   = neg_r_ff;
      rem_sel_in = rem_sel_ff;
      done_in    = 1'b0;
      if (req.start) begin
         run_in     = 1'b1;
         cnt_in     = CW'(WORD_BITS);
         quo_in     = dividend[WORD_BITS-1] ? 0 - dividend : dividend;
         mb_in      = divisor[WORD_BITS-1] ? 0 - divisor : divisor;
         rem_in     = '0;
         neg_q_in   = dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
         neg_r_in   = dividend[WORD_BITS-1];
         rem_sel_in = req.want_rem;
      end else if (run_ff) begin
         if (!trial[WORD_BITS]) begin
            rem_in = trial[WORD_BITS-1:0];
            quo_in = {quo_ff[WORD_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[WORD_BITS-1:0];
            quo_in = {quo_ff[WORD_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff     <= cnt_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      mb_ff      <= mb_in;
      neg_q_ff   <= neg_q_in;
      neg_r_ff   <= neg_r_in;
      rem_sel_ff <= rem_sel_in;
   end

   // apply signs to the magnitudes
   always_comb begin
      if (rem_sel_ff) result = neg_r_ff ? 0 - rem_ff : rem_ff;
      else            result = neg_q_ff ? 0 - quo_ff : quo_ff;
   end
   assign done = done_ff;

endmodule

[design/pcode_stack_machine_step_top.sv]
// Top level of the p-code stack machine: sequencer, data stack memory, ALU and divider.
//
//  channel   ports                                 handshake
//  request   start, busy, req_item                 taken when start && !busy
//  response  rsp_valid, rsp_item                   one-cycle strobe, no backpressure
//  config    csr_we, csr_wdata                     written when csr_we
//
// Each item runs a microcode sequence over the stack memory (one write port, one
// read port); each static link walked adds a read, and divide and modulo wait on
// the one-bit-per-cycle divider. The result strobe comes in the cycle after the
// sequence's last state; busy drops in that same cycle.
// Reset clears pointers, pc, halted flag and program_length (to 1); the stack memory
// is not cleared. The receiver cannot stall, so results never wait.
module pcode_stack_machine_step_top import pcsm_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int MAX_LEVEL   = MAX_LEVEL_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int XW = 34;
   typedef logic signed [XW-1:0] wide_type;
   localparam wide_type DEPTH_X = wide_type'(STACK_DEPTH);
   localparam wide_type TOP_X   = DEPTH_X - 1;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_DEC   = 5'd1;
   localparam logic [4:0] S_WALK  = 5'd2;
   localparam logic [4:0] S_WALKW = 5'd3;
   localparam logic [4:0] S_LODW  = 5'd4;
   localparam logic [4:0] S_STOW  = 5'd5;
   localparam logic [4:0] S_JPC   = 5'd6;
   localparam logic [4:0] S_RET1  = 5'd7;
   localparam logic [4:0] S_RET2  = 5'd8;
   localparam logic [4:0] S_UN    = 5'd9;
   localparam logic [4:0] S_BIN1  = 5'd10;
   localparam logic [4:0] S_BIN2  = 5'd11;
   localparam logic [4:0] S_DIV   = 5'd12;
   localparam logic [4:0] S_WRI   = 5'd13;
   localparam logic [4:0] S_LOD1A = 5'd14;
   localparam logic [4:0] S_LOD1B = 5'd15;
   localparam logic [4:0] S_CALR  = 5'd16;
   localparam logic [4:0] S_CAL1  = 5'd17;
   localparam logic [4:0] S_CAL2  = 5'd18;
   localparam logic [4:0] S_CAL3  = 5'd19;
   localparam logic [4:0] S_STO1A = 5'd20;
   localparam logic [4:0] S_STO1B = 5'd21;

   function automatic logic addr_ok(wide_type x);
      return !x[XW-1] && (x < DEPTH_X);
   endfunction

   logic [4:0]          state_ff, state_in;
   logic signed [AW:0]  sp_ff, sp_in;
   logic [AW-1:0]       base_ff, base_in;
   logic [15:0]         pc_ff, pc_in, plen_ff;
   logic                halted_ff, halted_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_item_ff, rsp_item_in;
   req_item_type        item_ff;
   wide_type            pos_ff, pos_in, addr_ff, addr_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] a_ff, a_in;

   logic [WORD_BITS-1:0] mem [STACK_DEPTH];
   logic [WORD_BITS-1:0] mem_rdata_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_wa, mem_ra;
   logic [WORD_BITS-1:0] mem_wd;

   div_req_type          div_req;
   logic                 div_done;
   logic signed [WORD_BITS-1:0] div_result;

   logic                 accept, fin, wv;
   logic [2:0]           fst;
   logic [16:0]          npc, npc_in;
   logic [WORD_BITS-1:0] wval, alu_r, bw;
   wide_type             sp_x, opd_x, base_x, rd_x, sum_x;
   logic [AW-1:0]        sp_m1, sp_p1, sp_p2, sp_p3;
   logic                 code_ill;

   assign accept = start && !busy;
   assign busy   = state_ff != S_IDLE;

   assign sp_x   = wide_type'(sp_ff);
   assign opd_x  = wide_type'(item_ff.operand);
   assign base_x = wide_type'({1'b0, base_ff});
   assign rd_x   = wide_type'($signed(mem_rdata_ff));
   assign sp_m1  = sp_ff[AW-1:0] - 1'b1;
   assign sp_p1  = sp_ff[AW-1:0] + 1'b1;
   assign sp_p2  = sp_ff[AW-1:0] + 2'd2;
   assign sp_p3  = sp_ff[AW-1:0] + 2'd3;
   assign npc    = {1'b0, pc_ff} + 17'd1;
   assign sum_x  = pos_ff + opd_x;
   assign bw     = mem_rdata_ff;
   assign code_ill = item_ff.operand < 0 || item_ff.operand > OPR_HALT ||
                     item_ff.operand == OPR_NONE;

   // shared ALU for the two-operand OPR codes other than divide and modulo
   always_comb begin
      unique case (item_ff.operand[4:0])
         5'(OPR_ADD): alu_r = a_ff + bw;
         5'(OPR_SUB): alu_r = a_ff - bw;
         5'(OPR_MUL): alu_r = a_ff * bw;
         5'(OPR_EQ):  alu_r = WORD_BITS'(a_ff == bw);
         5'(OPR_NE):  alu_r = WORD_BITS'(a_ff != bw);
         5'(OPR_LT):  alu_r = WORD_BITS'($signed(a_ff) < $signed(bw));
         5'(OPR_GE):  alu_r = WORD_BITS'(!($signed(a_ff) < $signed(bw)));
         5'(OPR_GT):  alu_r = WORD_BITS'($signed(bw) < $signed(a_ff));
         5'(OPR_LE):  alu_r = WORD_BITS'(!($signed(bw) < $signed(a_ff)));
         5'(OPR_XOR): alu_r = a_ff ^ bw;
         5'(OPR_AND): alu_r = WORD_BITS'(a_ff != 0 && bw != 0);
         default:     alu_r = WORD_BITS'(a_ff != 0 || bw != 0);
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      sp_in    = sp_ff;
      base_in  = base_ff;
      pc_in    = pc_ff;
      halted_in = halted_ff;
      pos_in   = pos_ff;
      addr_in  = addr_ff;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      npc_in   = npc;
      fin      = 1'b0;
      fst      = ST_OK;
      wv       = 1'b0;
      wval     = '0;
      mem_we   = 1'b0;
      mem_wa   = sp_p1;
      mem_wd   = '0;
      mem_ra   = sp_ff[AW-1:0];
      div_req  = '0;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (halted_ff || pc_ff >= plen_ff) begin
                  halted_in    = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_item_in  = '{next_pc: pc_ff, status: ST_END, write_valid: 1'b0,
                                   write_value: '0};
               end else begin
                  state_in = S_DEC;
               end
            end
         end
         S_DEC: begin
            if (32'(item_ff.level) > MAX_LEVEL) begin
               fin = 1'b1; fst = ST_ILL;
            end else begin
               unique case (item_ff.opcode)
                  OP_LIT: begin
                     fin = 1'b1;
                     if (sp_x >= TOP_X) fst = ST_FAULT;
                     else begin
                        mem_we = 1'b1; mem_wd = item_ff.operand; sp_in = sp_ff + 1'b1;
                     end
                  end
                  OP_LOD, OP_STO, OP_GTA: begin
                     pos_in = base_x; cnt_in = item_ff.level; state_in = S_WALK;
                  end
                  OP_INT: begin
                     fin = 1'b1;
                     if (sp_x + opd_x < -1 || sp_x + opd_x > TOP_X) fst = ST_FAULT;
                     else sp_in = (AW+1)'(sp_x + opd_x);
                  end
                  OP_JMP: begin
                     fin = 1'b1; npc_in = {1'b0, item_ff.operand[15:0]};
                  end
                  OP_JPC, OP_WRI, OP_LOD1: begin
                     if (sp_ff < 0) begin
                        fin = 1'b1; fst = ST_FAULT;
                     end else begin
                        unique case (item_ff.opcode)
                           OP_JPC:  state_in = S_JPC;
                           OP_WRI:  state_in = S_WRI;
                           default: state_in = S_LOD1A;
                        endcase
                     end
                  end
                  OP_OPR: begin
                     if (code_ill) begin
                        fin = 1'b1; fst = ST_ILL;
                     end else if (item_ff.operand == OPR_HALT) begin
                        fin = 1'b1; fst = ST_HALT;
                     end else if (item_ff.operand == OPR_RET) begin
                        if (npc == {1'b0, plen_ff}) begin
                           fin = 1'b1; fst = ST_END;
                        end else if (!addr_ok(base_x + 2)) begin
                           fin = 1'b1; fst = ST_FAULT;
                        end else begin
                           mem_ra = base_ff; state_in = S_RET1;
                        end
                     end else if (item_ff.operand == OPR_NOT || item_ff.operand == OPR_ODD)
                     begin
                        if (sp_ff < 0) begin
                           fin = 1'b1; fst = ST_FAULT;
                        end else state_in = S_UN;
                     end else if (sp_ff < 1) begin
                        fin = 1'b1; fst = ST_FAULT;
                     end else begin
                        mem_ra = sp_m1; state_in = S_BIN1;
                     end
                  end
                  OP_RED: begin
                     fin = 1'b1;
                     if (!addr_ok(opd_x)) fst = ST_FAULT;
                     else begin
                        mem_we = 1'b1; mem_wa = item_ff.operand[AW-1:0];
                        mem_wd = item_ff.read_value;
                     end
                  end
                  OP_CAL: begin
                     if (sp_x + 3 > TOP_X) begin
                        fin = 1'b1; fst = ST_FAULT;
                     end else if (item_ff.level != 0) begin
                        a_in = WORD_BITS'(base_ff); state_in = S_CAL1;
                     end else if (!addr_ok(base_x + 1)) begin
                        fin = 1'b1; fst = ST_FAULT;
                     end else begin
                        mem_ra = base_ff + 1'b1; state_in = S_CALR;
                     end
                  end
                  OP_STO1: begin
                     if (sp_ff < 1) begin
                        fin = 1'b1; fst = ST_FAULT;
                     end else begin
                        mem_ra = sp_m1; state_in = S_STO1A;
                     end
                  end
                  default: begin
                     fin = 1'b1; fst = ST_ILL;
                  end
               endcase
            end
         end
         // follow static links, one read per level
         S_WALK: begin
            if (cnt_ff != 0) begin
               if (!addr_ok(pos_ff + 1)) begin
                  fin = 1'b1; fst = ST_FAULT;
               end else begin
                  mem_ra = pos_ff[AW-1:0] + 1'b1;
                  cnt_in = cnt_ff - 1'b1;
                  state_in = S_WALKW;
               end
            end else begin
               unique case (item_ff.opcode)
                  OP_LOD: begin
                     if (!addr_ok(sum_x) || sp_x >= TOP_X) begin
                        fin = 1'b1; fst = ST_FAULT;
                     end else begin
                        mem_ra = sum_x[AW-1:0]; state_in = S_LODW;
                     end
                  end
                  OP_STO: begin
                     if (!addr_ok(sum_x) || sp_ff < 0) begin
                        fin = 1'b1; fst = ST_FAULT;
                     end else begin
                        addr_in = sum_x; state_in = S_STOW;
                     end
                  end
                  default: begin
                     fin = 1'b1;
                     if (sp_x >= TOP_X) fst = ST_FAULT;
                     else begin
                        mem_we = 1'b1; mem_wd = sum_x[WORD_BITS-1:0];
                        sp_in = sp_ff + 1'b1;
                     end
                  end
               endcase
            end
         end
         S_WALKW: begin
            pos_in = rd_x; state_in = S_WALK;
         end
         S_LODW: begin
            fin = 1'b1; mem_we = 1'b1; mem_wd = mem_rdata_ff; sp_in = sp_ff + 1'b1;
         end
         S_STOW: begin
            fin = 1'b1; mem_we = 1'b1; mem_wa = addr_ff[AW-1:0]; mem_wd = mem_rdata_ff;
            sp_in = sp_ff - 1'b1;
         end
         S_JPC: begin
            fin = 1'b1;
            if (mem_rdata_ff == 0) npc_in = {1'b0, item_ff.operand[15:0]};
            sp_in = sp_ff - 1'b1;
         end
         S_RET1: begin
            if (!addr_ok(rd_x)) begin
               fin = 1'b1; fst = ST_FAULT;
            end else begin
               a_in = mem_rdata_ff; mem_ra = base_ff + 2'd2; state_in = S_RET2;
            end
         end
         S_RET2: begin
            fin = 1'b1;
            sp_in = $signed({1'b0, base_ff}) - 1'b1;
            npc_in = {1'b0, mem_rdata_ff[15:0]};
            base_in = a_ff[AW-1:0];
         end
         S_UN: begin
            fin = 1'b1; mem_we = 1'b1; mem_wa = sp_ff[AW-1:0];
            mem_wd = (item_ff.operand == OPR_NOT) ? WORD_BITS'(mem_rdata_ff == 0)
                                                  : WORD_BITS'(mem_rdata_ff[0]);
         end
         S_BIN1: begin
            a_in = mem_rdata_ff; state_in = S_BIN2;
         end
         S_BIN2: begin
            if (item_ff.operand == OPR_DIV || item_ff.operand == OPR_MOD) begin
               if (bw == 0) begin
                  fin = 1'b1;
                  fst = (item_ff.operand == OPR_DIV) ? ST_DIV0 : ST_MOD0;
               end else begin
                  div_req = '{start: 1'b1, want_rem: item_ff.operand == OPR_MOD};
                  state_in = S_DIV;
               end
            end else begin
               fin = 1'b1; mem_we = 1'b1; mem_wa = sp_m1; mem_wd = alu_r;
               sp_in = sp_ff - 1'b1;
            end
         end
         S_DIV: begin
            if (div_done) begin
               fin = 1'b1; mem_we = 1'b1; mem_wa = sp_m1; mem_wd = div_result;
               sp_in = sp_ff - 1'b1;
            end
         end
         S_WRI: begin
            fin = 1'b1; wv = 1'b1; wval = mem_rdata_ff; sp_in = sp_ff - 1'b1;
         end
         S_LOD1A: begin
            if (!addr_ok(rd_x)) begin
               fin = 1'b1; fst = ST_FAULT;
            end else begin
               mem_ra = mem_rdata_ff[AW-1:0]; state_in = S_LOD1B;
            end
         end
         S_LOD1B: begin
            fin = 1'b1; mem_we = 1'b1; mem_wa = sp_ff[AW-1:0]; mem_wd = mem_rdata_ff;
         end
         S_CALR: begin
            a_in = mem_rdata_ff; state_in = S_CAL1;
         end
         // push the new frame: dynamic link, static link, return address
         S_CAL1: begin
            mem_we = 1'b1; mem_wd = WORD_BITS'(base_ff); state_in = S_CAL2;
         end
         S_CAL2: begin
            mem_we = 1'b1; mem_wa = sp_p2; mem_wd = a_ff; state_in = S_CAL3;
         end
         S_CAL3: begin
            fin = 1'b1; mem_we = 1'b1; mem_wa = sp_p3; mem_wd = WORD_BITS'(npc);
            base_in = sp_p1; npc_in = {1'b0, item_ff.operand[15:0]};
         end
         S_STO1A: begin
            if (!addr_ok(rd_x)) begin
               fin = 1'b1; fst = ST_FAULT;
            end else begin
               addr_in = rd_x; state_in = S_STO1B;
            end
         end
         S_STO1B: begin
            fin = 1'b1; mem_we = 1'b1; mem_wa = addr_ff[AW-1:0]; mem_wd = mem_rdata_ff;
            sp_in = sp_ff - (AW+1)'(2);
         end
         default: state_in = S_IDLE;
      endcase

      // close the item: commit or halt
      if (fin) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
         if (fst == ST_OK || fst == ST_DIV0) begin
            pc_in = npc_in[15:0];
            rsp_item_in = '{next_pc: npc_in[15:0], status: fst, write_valid: wv,
                            write_value: wval};
         end else begin
            sp_in     = sp_ff;
            base_in   = base_ff;
            halted_in = 1'b1;
            pc_in     = plen_ff;
            rsp_item_in = '{next_pc: plen_ff, status: fst, write_valid: 1'b0,
                            write_value: '0};
         end
      end
   end

   pcsm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .dividend (a_ff),
      .divisor  (bw),
      .done     (div_done),
      .result   (div_result)
   );

   // stack memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_rdata_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '1;
         base_ff      <= '0;
         pc_ff        <= '0;
         halted_ff    <= 1'b0;
         plen_ff      <= 16'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         base_ff      <= base_in;
         pc_ff        <= pc_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) plen_ff <= csr_wdata;
      end
      if (accept) item_ff <= req_item;
      rsp_item_ff <= rsp_item_in;
      pos_ff      <= pos_in;
      addr_ff     <= addr_in;
      cnt_ff      <= cnt_in;
      a_ff        <= a_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // a sequence always ends back in idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_IDLE) else $error("response outside idle");
   // stack pointer stays within empty..full
   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_x >= -1 && sp_x < DEPTH_X) else $error("stack pointer out of range");
   // only a successful WRI reports a value
   a_wri_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.write_valid |-> rsp_item_ff.status == ST_OK)
      else $error("write value on failed item");
   // divider finishes only while waited on
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV) else $error("stray divider result");
   // a halted machine never leaves halt
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff) else $error("halt flag dropped");

endmodule

[tb/pcode_stack_machine_step_top_test.sv]
// Self-checking testbench for the p-code stack machine step block.
`timescale 1ns / 1ps

module pcode_stack_machine_step_top_test;
   import pcsm_pkg::*;

   localparam int          DEPTH            = STACK_DEPTH_DEF;
   localparam int          TOP_INDEX        = DEPTH - 1;
   localparam logic [3:0]  OP_FIRST_ILLEGAL = 4'd13;
   localparam int          SETTLE_CYCLES    = 60;

   // Tracks machine state, predicts each item's result and holds expectations.
   class stack_machine_tracker;
      logic [31:0]  mem [DEPTH];
      bit           written [DEPTH];
      longint       sp;
      longint       base;
      longint       pc;
      bit           halted;
      int           prog_len;
      bit           blank_hit;
      rsp_item_type expected_results [$];
      int           errors;
      int           results_seen;

      function new();
         for (int i = 0; i < DEPTH; i++) begin
            mem[i] = '0;
            written[i] = 1'b0;
         end
         sp = -1;
         base = 0;
         pc = 0;
         halted = 0;
         prog_len = 1;
         errors = 0;
         results_seen = 0;
      endfunction

      function bit in_range(longint a);
         return a >= 0 && a < DEPTH;
      endfunction

      function longint sx(logic [31:0] v);
         return longint'($signed(v));
      endfunction

      function logic [31:0] fetch(longint a);
         if (!written[a]) blank_hit = 1;
         return mem[a];
      endfunction

      function void store(longint a, logic [31:0] v, bit commit);
         if (commit) begin
            mem[a] = v;
            written[a] = 1'b1;
         end
      endfunction

      // Follow static links from the frame base.
      function bit walk_links(int lvl, output longint pos);
         pos = base;
         for (int k = 0; k < lvl; k++) begin
            if (!in_range(pos + 1)) return 0;
            pos = sx(fetch(pos + 1));
         end
         return 1;
      endfunction

      // Execute one instruction; state changes only when commit is set.
      function void exec_instruction(input req_item_type it, input bit commit,
                                     output rsp_item_type rsp, output bit blank);
         longint       ops, nsp, nbase, npc, pos, addr;
         logic [31:0]  a, b, res;
         logic [2:0]   st;
         bit           wvalid;
         logic [31:0]  wval;
         blank_hit = 0;
         ops = longint'(it.operand);
         nsp = sp;
         nbase = base;
         npc = pc + 1;
         st = ST_OK;
         wvalid = 0;
         wval = '0;
         rsp = '0;
         if (halted || pc >= prog_len) begin
            if (commit) halted = 1;
            rsp.next_pc = pc[15:0];
            rsp.status = ST_END;
            blank = 0;
            return;
         end
         case (it.opcode)
            OP_LIT: begin
               if (nsp >= TOP_INDEX) st = ST_FAULT;
               else begin
                  store(nsp + 1, it.operand, commit);
                  nsp++;
               end
            end
            OP_LOD: begin
               if (!walk_links(it.level, pos) || !in_range(pos + ops) || nsp >= TOP_INDEX)
                  st = ST_FAULT;
               else begin
                  a = fetch(pos + ops);
                  store(nsp + 1, a, commit);
                  nsp++;
               end
            end
            OP_STO: begin
               if (!walk_links(it.level, pos) || !in_range(pos + ops) || nsp < 0)
                  st = ST_FAULT;
               else begin
                  a = fetch(nsp);
                  store(pos + ops, a, commit);
                  nsp--;
               end
            end
            OP_INT: begin
               if (nsp + ops < -1 || nsp + ops > TOP_INDEX) st = ST_FAULT;
               else nsp += ops;
            end
            OP_JMP: npc = it.operand[15:0];
            OP_JPC: begin
               if (nsp < 0) st = ST_FAULT;
               else begin
                  if (fetch(nsp) == 0) npc = it.operand[15:0];
                  nsp--;
               end
            end
            OP_OPR: begin
               if (ops < 0 || ops > OPR_HALT || ops == OPR_NONE) st = ST_ILL;
               else if (ops == OPR_HALT) st = ST_HALT;
               else if (ops == OPR_RET) begin
                  if (npc == prog_len) st = ST_END;
                  else if (!in_range(base + 2)) st = ST_FAULT;
                  else begin
                     addr = sx(fetch(base));
                     if (!in_range(addr)) st = ST_FAULT;
                     else begin
                        nsp = base - 1;
                        npc = fetch(base + 2) & 32'hFFFF;
                        nbase = addr;
                     end
                  end
               end else if (ops == OPR_NOT || ops == OPR_ODD) begin
                  if (nsp < 0) st = ST_FAULT;
                  else begin
                     a = fetch(nsp);
                     res = (ops == OPR_NOT) ? 32'(a == 0) : 32'(a[0]);
                     store(nsp, res, commit);
                  end
               end else if (nsp < 1) st = ST_FAULT;
               else begin
                  a = fetch(nsp - 1);
                  b = fetch(nsp);
                  case (int'(ops))
                     OPR_ADD: res = a + b;
                     OPR_SUB: res = a - b;
                     OPR_MUL: res = a * b;
                     OPR_DIV: begin
                        if (b == 0) st = ST_DIV0;
                        else res = 32'(sx(a) / sx(b));
                     end
                     OPR_EQ:  res = 32'(a == b);
                     OPR_NE:  res = 32'(a != b);
                     OPR_LT:  res = 32'($signed(a) < $signed(b));
                     OPR_GE:  res = 32'($signed(a) >= $signed(b));
                     OPR_GT:  res = 32'($signed(a) > $signed(b));
                     OPR_LE:  res = 32'($signed(a) <= $signed(b));
                     OPR_MOD: begin
                        if (b == 0) st = ST_MOD0;
                        else res = 32'(sx(a) % sx(b));
                     end
                     OPR_XOR: res = a ^ b;
                     OPR_AND: res = 32'(a != 0 && b != 0);
                     default: res = 32'(a != 0 || b != 0);
                  endcase
                  if (st == ST_OK) begin
                     store(nsp - 1, res, commit);
                     nsp--;
                  end
               end
            end
            OP_RED: begin
               if (!in_range(ops)) st = ST_FAULT;
               else store(ops, it.read_value, commit);
            end
            OP_WRI: begin
               if (nsp < 0) st = ST_FAULT;
               else begin
                  wvalid = 1;
                  wval = fetch(nsp);
                  nsp--;
               end
            end
            OP_LOD1: begin
               if (nsp < 0) st = ST_FAULT;
               else begin
                  addr = sx(fetch(nsp));
                  if (!in_range(addr)) st = ST_FAULT;
                  else store(nsp, fetch(addr), commit);
               end
            end
            OP_GTA: begin
               if (!walk_links(it.level, pos) || nsp >= TOP_INDEX) st = ST_FAULT;
               else begin
                  store(nsp + 1, 32'(pos + ops), commit);
                  nsp++;
               end
            end
            OP_CAL: begin
               if (nsp + 3 > TOP_INDEX) st = ST_FAULT;
               else if (it.level == 0 && !in_range(base + 1)) st = ST_FAULT;
               else begin
                  res = (it.level != 0) ? 32'(base) : fetch(base + 1);
                  store(nsp + 1, 32'(base), commit);
                  store(nsp + 2, res, commit);
                  store(nsp + 3, 32'(npc), commit);
                  nbase = nsp + 1;
                  npc = it.operand[15:0];
               end
            end
            OP_STO1: begin
               if (nsp < 1) st = ST_FAULT;
               else begin
                  addr = sx(fetch(nsp - 1));
                  if (!in_range(addr)) st = ST_FAULT;
                  else begin
                     store(addr, fetch(nsp), commit);
                     nsp -= 2;
                  end
               end
            end
            default: st = ST_ILL;
         endcase
         if (st == ST_OK || st == ST_DIV0) begin
            if (commit) begin
               sp = nsp;
               base = nbase;
               pc = npc & 16'hFFFF;
            end
            rsp.next_pc = npc[15:0];
            rsp.write_valid = wvalid;
            rsp.write_value = wval;
         end else begin
            if (commit) begin
               halted = 1;
               pc = prog_len;
            end
            rsp.next_pc = prog_len[15:0];
         end
         rsp.status = st;
         blank = blank_hit;
      endfunction

      // True when the item keeps the machine running and reads only written entries.
      function bit keeps_running(req_item_type it);
         rsp_item_type r;
         bit           blank;
         exec_instruction(it, 0, r, blank);
         return !blank && (r.status == ST_OK || r.status == ST_DIV0) && r.next_pc < prog_len;
      endfunction

      function bit reads_only_written(req_item_type it);
         rsp_item_type r;
         bit           blank;
         exec_instruction(it, 0, r, blank);
         return !blank;
      endfunction

      function void note_instruction(req_item_type it);
         rsp_item_type r;
         bit           blank;
         exec_instruction(it, 1, r, blank);
         expected_results.insert(expected_results.size(), r);
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         results_seen++;
         if (expected_results.size() == 0) begin
            $error("result with nothing expected: %p", got);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         if (got.next_pc !== want.next_pc) begin
            $error("next_pc: expected %0d, actual %0d", want.next_pc, got.next_pc);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
         if (got.write_valid !== want.write_valid) begin
            $error("write_valid: expected %0b, actual %0b", want.write_valid, got.write_valid);
            errors++;
         end
         if (got.write_value !== want.write_value) begin
            $error("write_value: expected %0h, actual %0h", want.write_value, got.write_value);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         csr_we;
   logic [15:0]  csr_wdata;

   stack_machine_tracker machine = new();
   int                   items_sent;

   pcode_stack_machine_step_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Check every strobed result.
   always @(posedge clock) begin
      if (!reset && rsp_valid) machine.check_result(rsp_item);
   end

   // Hold the item until taken, then sometimes idle for a random gap.
   task automatic send_item(req_item_type it);
      int pick, gap;
      start <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      machine.note_instruction(it);
      items_sent++;
      pick = $urandom_range(0, 9);
      gap = (pick < 5) ? 0 : (pick < 9) ? $urandom_range(1, 3) : $urandom_range(10, 30);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic req_item_type make_item(logic [3:0] opc, logic [2:0] lvl,
                                              logic [31:0] opnd);
      req_item_type it;
      it.opcode = opc;
      it.level = lvl;
      it.operand = opnd;
      it.read_value = $urandom;
      return it;
   endfunction

   // Send only items that keep the machine alive and read written entries.
   task automatic send_if_running(req_item_type it);
      if (machine.keeps_running(it)) send_item(it);
   endtask

   task automatic push_pair_and_op(logic [31:0] x, logic [31:0] y, int code);
      send_if_running(make_item(OP_LIT, 3'd0, x));
      send_if_running(make_item(OP_LIT, 3'd0, y));
      send_if_running(make_item(OP_OPR, 3'd0, 32'(code)));
      send_if_running(make_item(OP_WRI, 3'd0, 32'd0));
   endtask

   // Drain, settle, then write program length.
   task automatic set_program_length(logic [15:0] len);
      start <= 1'b0;
      while (machine.expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= len;
      @(posedge clock);
      csr_we <= 1'b0;
      machine.prog_len = len;
   endtask

   function automatic req_item_type random_instruction();
      req_item_type it;
      int           w, hi;
      hi = (machine.sp < 0) ? 4 : int'(machine.sp) + 4;
      if (hi > TOP_INDEX) hi = TOP_INDEX;
      w = $urandom_range(0, 99);
      it.level = $urandom_range(0, 7);
      it.read_value = $urandom;
      if (w < 15) begin
         it.opcode = OP_LIT;
         it.operand = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, hi);
      end else if (w < 25) begin
         it.opcode = ($urandom_range(0, 1) != 0) ? OP_LOD : OP_STO;
         it.operand = $urandom_range(0, 12);
      end else if (w < 32) begin
         it.opcode = OP_INT;
         it.operand = (machine.sp > 100) ? -$urandom_range(1, 20) : $urandom_range(0, 8) - 4;
      end else if (w < 37) begin
         it.opcode = ($urandom_range(0, 1) != 0) ? OP_JMP : OP_JPC;
         it.operand = $urandom_range(0, machine.prog_len - 1);
      end else if (w < 62) begin
         it.opcode = OP_OPR;
         it.operand = $urandom_range(0, 17);
      end else if (w < 68) begin
         it.opcode = OP_RED;
         it.operand = $urandom_range(0, hi);
      end else if (w < 75) begin
         it.opcode = OP_WRI;
         it.operand = $urandom;
      end else if (w < 80) begin
         it.opcode = OP_LOD1;
         it.operand = $urandom;
      end else if (w < 86) begin
         it.opcode = OP_GTA;
         it.operand = $urandom_range(0, 12);
      end else if (w < 91) begin
         it.opcode = OP_CAL;
         it.operand = $urandom_range(0, machine.prog_len - 1);
      end else if (w < 96) begin
         it.opcode = OP_STO1;
         it.operand = $urandom;
      end else begin
         // noise: any legal opcode, any operand
         it.opcode = $urandom_range(0, 12);
         it.operand = $urandom;
      end
      return it;
   endfunction

   task automatic run_random(int count);
      req_item_type it;
      bit           found;
      for (int n = 0; n < count; n++) begin
         found = 0;
         for (int t = 0; t < 60 && !found; t++) begin
            it = random_instruction();
            found = machine.keeps_running(it);
         end
         if (!found) it = make_item(OP_JMP, 3'($urandom), $urandom_range(0, machine.prog_len - 1));
         send_item(it);
      end
   endtask

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

   initial begin
      req_item_type it;
      int           pick;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      items_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_program_length(16'hFFFF);

      // Frame of main: dynamic link, static link and return slots all zero.
      repeat (3) send_if_running(make_item(OP_LIT, 3'd0, 32'd0));
      send_if_running(make_item(OP_LOD, 3'd7, 32'd1));
      send_if_running(make_item(OP_GTA, 3'd5, 32'd2));
      send_if_running(make_item(OP_LOD1, 3'd0, 32'd0));
      send_if_running(make_item(OP_WRI, 3'd0, 32'd0));
      push_pair_and_op(32'h8000_0000, 32'hFFFF_FFFF, OPR_DIV);
      push_pair_and_op(32'h8000_0000, 32'hFFFF_FFFF, OPR_MOD);
      push_pair_and_op(32'h7FFF_FFFF, 32'h0000_0001, OPR_ADD);
      push_pair_and_op(32'h8000_0000, 32'h0000_0001, OPR_SUB);
      push_pair_and_op(32'h0001_0003, 32'h0001_0007, OPR_MUL);
      push_pair_and_op(32'd5, 32'd0, OPR_DIV);
      push_pair_and_op(-32'sd7, 32'sd2, OPR_MOD);
      for (int code = OPR_EQ; code <= OPR_OR; code++)
         push_pair_and_op($urandom_range(0, 1) ? 32'h8000_0000 : $urandom_range(0, 2),
                          $urandom_range(0, 1) ? 32'h7FFF_FFFF : $urandom_range(0, 2), code);
      send_if_running(make_item(OP_LIT, 3'd0, 32'd0));
      send_if_running(make_item(OP_OPR, 3'd0, 32'(OPR_NOT)));
      send_if_running(make_item(OP_OPR, 3'd0, 32'(OPR_ODD)));
      send_if_running(make_item(OP_JPC, 3'd0, 32'hFFFF_0005));
      send_if_running(make_item(OP_RED, 3'd0, 32'(TOP_INDEX)));
      // Stack to its very top and back down.
      send_if_running(make_item(OP_INT, 3'd0, 32'(TOP_INDEX - 2)));
      send_if_running(make_item(OP_INT, 3'd0, -32'(TOP_INDEX - 2)));
      send_if_running(make_item(OP_CAL, 3'd1, 32'd40));
      send_if_running(make_item(OP_OPR, 3'd0, 32'(OPR_RET)));
      send_if_running(make_item(OP_CAL, 3'd0, 32'hFFFE));
      send_if_running(make_item(OP_JMP, 3'd0, 32'd0));

      run_random(400);

      // Short program: jump home, then shrink.
      send_item(make_item(OP_JMP, 3'd0, 32'd0));
      set_program_length($urandom_range(40, 2000));
      run_random(380);

      send_item(make_item(OP_JMP, 3'd0, 32'd0));
      set_program_length(16'd1);
      send_item(make_item(OP_JMP, 3'd0, 32'd0));

      // End execution with one halting item, then items that are ignored.
      pick = $urandom_range(0, 3);
      case (pick)
         0: it = make_item(OP_OPR, 3'd0, 32'(OPR_RET));
         1: it = make_item(OP_OPR, 3'd0, 32'(OPR_HALT));
         2: it = make_item(OP_FIRST_ILLEGAL + 4'($urandom_range(0, 2)), 3'($urandom), $urandom);
         default: it = make_item(OP_OPR, 3'd0, ($urandom_range(0, 1) != 0) ?
                                 32'(OPR_NONE) : $urandom | 32'h8000_0000);
      endcase
      send_item(it);
      for (int n = 0; n < 3; n++) begin
         it = random_instruction();
         if (machine.reads_only_written(it)) send_item(it);
      end

      start <= 1'b0;
      while (machine.expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d instructions, %0d results; program lengths 65535, random and 1",
               items_sent, machine.results_seen);
      $display("ran every opcode and OPR code, deep static-link walks and a final halt");
      if (machine.errors == 0 && machine.expected_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
